### rtl/positional_list_engine_assert.svh
// Assertion macros used by the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int POS_W      = 5;
  localparam int IN_KEY_W   = 16;
  localparam int IN_PAY_W   = 32;
  localparam int USER_W     = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOKEY  = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ROT  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_DEL  = 2'd3
  } cell_op_e;

endpackage

### rtl/ple_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module ple_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int KW  = 16,
  parameter int PW  = 32
) (
  input  logic               clk_i,
  input  ple_pkg::cell_op_e  op_i,
  input  logic [IW-1:0]      tgt_i,
  input  logic [KW-1:0]      new_key_i,
  input  logic [PW-1:0]      new_pay_i,
  input  logic [KW-1:0]      left_key_i,
  input  logic [PW-1:0]      left_pay_i,
  input  logic [KW-1:0]      right_key_i,
  input  logic [PW-1:0]      right_pay_i,
  output logic [KW-1:0]      key_o,
  output logic [PW-1:0]      pay_o
);
  import ple_pkg::*;

  localparam logic [IW-1:0] Me = IW'(IDX);

  logic [KW-1:0] key_q, key_d;
  logic [PW-1:0] pay_q, pay_d;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    case (op_i)
      CELL_ROT: begin
        key_d = right_key_i;
        pay_d = right_pay_i;
      end
      CELL_INS: begin
        if (Me == tgt_i) begin
          key_d = new_key_i;
          pay_d = new_pay_i;
        end else if (Me > tgt_i) begin
          key_d = left_key_i;
          pay_d = left_pay_i;
        end
      end
      CELL_DEL: begin
        if (Me >= tgt_i) begin
          key_d = right_key_i;
          pay_d = right_pay_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

### rtl/positional_list_engine.sv
// Top level of the positional list engine: stream ports, sequencer and the ring of cells.
`timescale 1ns / 1ps
`include "positional_list_engine_assert.svh"

// The list lives in a ring of DEPTH cells, position p in cell p-1. Insert, and any
// operation rejected for a bad position or a full list, loads its result beat as it
// is accepted: all cells shift at once. Get, delete and locate rotate the ring once
// around through the head cell, which is the only place an entry is read, then load
// the result beat in a finishing state that waits for a free output register; a
// delete closes the gap there. One operation is in progress at a time, and a new input
// beat is taken only when the output register is empty or its result beat leaves
// in the same cycle. Keys and payloads keep their low KEY_BITS and PAYLOAD_BITS bits
// (at most 16 and 32). Stored entries need no clearing after reset.
module positional_list_engine #(
  parameter int DEPTH        = 16,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // position, entry_key, entry_payload, zero fill (lowest bit first)
  input  logic [ple_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic [ple_pkg::USER_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // found_position, out_key, out_payload, list_length, zero fill (lowest bit first)
  output logic [ple_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status
  output logic [ple_pkg::USER_W-1:0]         m_axis_tuser
);
  import ple_pkg::*;

  localparam int KW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int PW = (PAYLOAD_BITS < IN_PAY_W) ? PAYLOAD_BITS : IN_PAY_W;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [IW-1:0] ScanLast = IW'(DEPTH - 1);
  localparam int FillW = OUT_DATA_W - (3 * POS_W + IN_KEY_W + IN_PAY_W) + POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic           found_q, found_d;
  logic           ovalid_q, ovalid_d;
  op_e            op_q, op_d;
  logic [IW-1:0]  tgt_q, tgt_d;
  logic [IW-1:0]  scan_q, scan_d;
  logic [KW-1:0]  skey_q, skey_d;
  logic [KW-1:0]  hkey_q, hkey_d;
  logic [PW-1:0]  hpay_q, hpay_d;
  logic [POS_W-1:0] fpos_q, fpos_d;
  logic [OUT_DATA_W-1:0] odata_q;
  logic [USER_W-1:0]     ouser_q;

  logic [KW-1:0]  ckey [DEPTH];
  logic [PW-1:0]  cpay [DEPTH];
  cell_op_e       cell_op;
  logic [IW-1:0]  cell_tgt;

  op_e            op_in;
  logic [POS_W-1:0] pos_in;
  logic [KW-1:0]  key_in;
  logic [PW-1:0]  pay_in;
  logic [EW-1:0]  posx, cntx, cntdx;
  logic           in_acc, out_free, ins_full, ins_bad, rd_bad, load;
  status_e        res_status;
  logic [POS_W-1:0] res_found;
  logic [KW-1:0]  res_key;
  logic [PW-1:0]  res_pay;

  assign op_in  = op_e'(s_axis_tuser[1:0]);
  assign pos_in = s_axis_tdata[POS_W-1:0];
  assign key_in = s_axis_tdata[POS_W +: KW];
  assign pay_in = s_axis_tdata[POS_W + IN_KEY_W +: PW];

  assign posx     = EW'(pos_in);
  assign cntx     = EW'(count_q);
  assign cntdx    = EW'(count_d);
  assign ins_full = (cntx == EW'(DEPTH));
  assign ins_bad  = (posx == '0) || (posx > cntx + 1'b1);
  assign rd_bad   = (posx == '0) || (posx > cntx);

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int L = (g == 0) ? DEPTH - 1 : g - 1;
    localparam int R = (g == DEPTH - 1) ? 0 : g + 1;
    ple_cell #(
      .IDX (g),
      .IW  (IW),
      .KW  (KW),
      .PW  (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .tgt_i       (cell_tgt),
      .new_key_i   (key_in),
      .new_pay_i   (pay_in),
      .left_key_i  (ckey[L]),
      .left_pay_i  (cpay[L]),
      .right_key_i (ckey[R]),
      .right_pay_i (cpay[R]),
      .key_o       (ckey[g]),
      .pay_o       (cpay[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    found_d    = found_q;
    op_d       = op_q;
    tgt_d      = tgt_q;
    scan_d     = scan_q;
    skey_d     = skey_q;
    hkey_d     = hkey_q;
    hpay_d     = hpay_q;
    fpos_d     = fpos_q;
    cell_op    = CELL_HOLD;
    cell_tgt   = tgt_q;
    load       = 1'b0;
    res_status = ST_OK;
    res_found  = '0;
    res_key    = '0;
    res_pay    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = op_in;
          tgt_d   = IW'(posx - 1'b1);
          skey_d  = key_in;
          scan_d  = '0;
          found_d = 1'b0;
          fpos_d  = '0;
          case (op_in)
            OP_INSERT: begin
              load = 1'b1;
              if (ins_full) begin
                res_status = ST_FULL;
              end else if (ins_bad) begin
                res_status = ST_BADPOS;
              end else begin
                cell_op  = CELL_INS;
                cell_tgt = IW'(posx - 1'b1);
                count_d  = CW'(cntx + 1'b1);
              end
            end
            OP_LOCATE: begin
              state_d = S_SCAN;
            end
            default: begin
              if (rd_bad) begin
                load       = 1'b1;
                res_status = ST_BADPOS;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // The head cell holds the entry at position scan_q + 1 in this cycle.
        cell_op = CELL_ROT;
        scan_d  = scan_q + 1'b1;
        if (scan_q == tgt_q) begin
          hkey_d = ckey[0];
          hpay_d = cpay[0];
        end
        if (!found_q && (EW'(scan_q) < cntx) && (ckey[0] == skey_q)) begin
          found_d = 1'b1;
          fpos_d  = POS_W'(EW'(scan_q) + 1'b1);
        end
        if (scan_q == ScanLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          case (op_q)
            OP_LOCATE: begin
              res_status = found_q ? ST_OK : ST_NOKEY;
              res_found  = found_q ? fpos_q : '0;
            end
            OP_DELETE: begin
              res_key  = hkey_q;
              res_pay  = hpay_q;
              cell_op  = CELL_DEL;
              count_d  = CW'(cntx - 1'b1);
            end
            default: begin
              res_key = hkey_q;
              res_pay = hpay_q;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tgt_q  <= tgt_d;
    scan_q <= scan_d;
    skey_q <= skey_d;
    hkey_q <= hkey_d;
    hpay_q <= hpay_d;
    fpos_q <= fpos_d;
    if (load) begin
      odata_q <= {{FillW{1'b0}}, cntdx[POS_W-1:0], IN_PAY_W'(res_pay),
                  IN_KEY_W'(res_key), res_found};
      ouser_q <= res_status;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  `PLE_ASSERT_NXT(a_ins_grows, clk_i, rst_ni,
                  in_acc && (op_in == OP_INSERT) && !ins_full && !ins_bad,
                  count_q == $past(count_q) + 1'b1, "insert did not grow the list")
  `PLE_ASSERT_NXT(a_scan_ends, clk_i, rst_ni,
                  (state_q == S_SCAN) && (scan_q == ScanLast), state_q == S_FIN,
                  "rotation did not end after one full turn")
  `PLE_ASSERT_NXT(a_fin_result, clk_i, rst_ni,
                  (state_q == S_FIN) && out_free, (state_q == S_IDLE) && m_axis_tvalid,
                  "finished operation gave no result beat")
  `PLE_ASSERT_IMP(a_len_bound, clk_i, rst_ni, state_q == S_SCAN, cntx <= EW'(DEPTH),
                  "list length above depth during rotation")

endmodule
